FILE: rtl/aitb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitb_pkg
// Shared types, widths and constants of the swept box time-of-impact search.
// ----------------------------------------------------------------------------
package aitb_pkg;

  localparam int MAX_COLLIDERS = 8;
  localparam int ITERATIONS    = 8;

  localparam int POS_W     = 24;
  localparam int SIZE_W    = 23;
  localparam int TIME_W    = 17;
  localparam int TIME_FRAC = 16;
  localparam int PROD_W    = TIME_W + POS_W;
  localparam int DISP_W    = PROD_W - TIME_FRAC;
  localparam int SUM_W     = DISP_W + 1;
  localparam int CMP_W     = SUM_W + 2;

  localparam int CNT_W  = $clog2(MAX_COLLIDERS + 1);
  localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  // The first bisection step is a quarter frame.
  localparam int STEP_LOG = TIME_FRAC - 2;

  localparam logic signed [TIME_W-1:0] T_START = -TIME_W'(1 << (TIME_FRAC - 1));
  localparam logic signed [TIME_W-1:0] T_NONE  = -TIME_W'(1 << TIME_FRAC);

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
  } aitb_box_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_STEP,
    S_SETTLE,
    S_DONE
  } aitb_state_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SUM_W'(POS_MAX)) begin
      r = POS_MAX;
    end else if (v < SUM_W'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/aitb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitb_in_if
// Input channel: collider appends and moving-box search requests.
// ----------------------------------------------------------------------------
interface aitb_in_if import aitb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [SIZE_W-1:0]       box_width;
  logic [SIZE_W-1:0]       box_height;
  logic signed [POS_W-1:0] vel_x;
  logic signed [POS_W-1:0] vel_y;

  modport source (output valid, cmd, pos_x, pos_y, box_width, box_height, vel_x, vel_y,
                  input ready);
  modport sink (input valid, cmd, pos_x, pos_y, box_width, box_height, vel_x, vel_y,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/aitb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitb_out_if
// Result channel: impact time and the moving box position at that time.
// ----------------------------------------------------------------------------
interface aitb_out_if import aitb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TIME_W-1:0] impact_time;
  logic                     free_found;
  logic signed [POS_W-1:0]  new_x;
  logic signed [POS_W-1:0]  new_y;

  modport source (output valid, impact_time, free_found, new_x, new_y, input ready);
  modport sink (input valid, impact_time, free_found, new_x, new_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/aabb_impact_time_bisection.sv
// ----------------------------------------------------------------------------
// aabb_impact_time_bisection
// Each bisection step of a search rotates the whole collider chain past one shared
// overlap tester. A new transaction is accepted only after the search has handed its
// result to the output register. Reset clears the control state and the collider count;
// the collider slots themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_impact_time_bisection import aitb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  aitb_in_if.sink     in_ch,
  aitb_out_if.source  out_ch
);

  aitb_state_t state_r;
  aitb_state_t state_nxt;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         j_r;
  logic [ITER_W-1:0]        i_r;
  aitb_box_t                mov_r;
  logic signed [TIME_W-1:0] t_r;
  logic signed [TIME_W-1:0] rt_r;
  logic                     found_r;
  logic                     hit_acc_r;
  logic signed [DISP_W-1:0] dax_r;
  logic signed [DISP_W-1:0] day_r;
  logic signed [PROD_W-1:0] prod_ax;
  logic signed [PROD_W-1:0] prod_ay;
  logic signed [SUM_W-1:0]  px;
  logic signed [SUM_W-1:0]  py;

  logic                     out_valid_r;
  logic signed [TIME_W-1:0] out_time_r;
  logic                     out_found_r;
  logic signed [POS_W-1:0]  out_x_r;
  logic signed [POS_W-1:0]  out_y_r;

  logic in_acc;
  logic in_ready;
  logic rotate;
  logic shift_en;
  logic probe_valid;
  logic out_load;
  logic tester_hit;
  logic step_hit;

  logic [TIME_W-1:0]        step_val;
  logic signed [TIME_W-1:0] t_next;
  logic signed [TIME_W-1:0] rt_next;

  aitb_box_t in_box;
  aitb_box_t head_box;
  aitb_box_t cell_q [MAX_COLLIDERS];

  assign in_acc = in_ch.valid && in_ready;

  assign in_box.x  = in_ch.pos_x;
  assign in_box.y  = in_ch.pos_y;
  assign in_box.w  = in_ch.box_width;
  assign in_box.h  = in_ch.box_height;
  assign in_box.vx = in_ch.vel_x;
  assign in_box.vy = in_ch.vel_y;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.cmd == CMD_SEARCH) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (j_r == CNT_W'(MAX_COLLIDERS - 1)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (i_r == ITER_W'(ITERATIONS - 1)) begin
          state_nxt = S_SETTLE;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_SETTLE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    rotate   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_RUN: begin
        rotate = 1'b1;
      end
      S_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Slots below the count reach the tail of the chain only once j is at least MAX_COLLIDERS minus the count.
  assign probe_valid = rotate &&
                       ((CNT_W+1)'(j_r) + (CNT_W+1)'(count_r) >= (CNT_W+1)'(MAX_COLLIDERS));
  assign shift_en = rotate ||
                    (in_acc && in_ch.cmd == CMD_APPEND && count_r < CNT_W'(MAX_COLLIDERS));
  assign head_box = rotate ? cell_q[MAX_COLLIDERS-1] : in_box;

  for (genvar k = 0; k < MAX_COLLIDERS; k++) begin : g_chain
    if (k == 0) begin : g_head
      aitb_cell u_cell (.clk(clk), .shift_en(shift_en), .d(head_box), .q(cell_q[k]));
    end else begin : g_body
      aitb_cell u_cell (.clk(clk), .shift_en(shift_en), .d(cell_q[k-1]), .q(cell_q[k]));
    end
  end

  assign prod_ax = PROD_W'(t_r) * PROD_W'(mov_r.vx);
  assign prod_ay = PROD_W'(t_r) * PROD_W'(mov_r.vy);
  assign px = SUM_W'(mov_r.x) + SUM_W'(dax_r);
  assign py = SUM_W'(mov_r.y) + SUM_W'(day_r);

  aitb_test u_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent       (cell_q[MAX_COLLIDERS-1]),
    .ent_valid (probe_valid),
    .t         (t_r),
    .px        (px),
    .py        (py),
    .aw        (mov_r.w),
    .ah        (mov_r.h),
    .hit       (tester_hit)
  );

  assign step_hit = hit_acc_r || tester_hit;
  assign step_val = TIME_W'(1) << (5'(STEP_LOG) - 5'(i_r));
  assign t_next   = step_hit ? (t_r - step_val) : (t_r + step_val);
  assign rt_next  = step_hit ? rt_r : t_r;

  always_ff @(posedge clk) begin
    dax_r <= prod_ax[PROD_W-1:TIME_FRAC];
    day_r <= prod_ay[PROD_W-1:TIME_FRAC];
    if (in_acc) begin
      mov_r <= in_box;
    end
    if (out_load) begin
      out_time_r  <= rt_r;
      out_found_r <= found_r;
      out_x_r     <= sat_pos(px);
      out_y_r     <= sat_pos(py);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      j_r         <= '0;
      i_r         <= '0;
      t_r         <= T_START;
      rt_r        <= T_NONE;
      found_r     <= 1'b0;
      hit_acc_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (shift_en && !rotate) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (in_acc && in_ch.cmd == CMD_SEARCH) begin
        t_r       <= T_START;
        rt_r      <= T_NONE;
        found_r   <= 1'b0;
        i_r       <= '0;
        j_r       <= '0;
        hit_acc_r <= 1'b0;
      end
      if (rotate) begin
        j_r <= (j_r == CNT_W'(MAX_COLLIDERS - 1)) ? '0 : j_r + CNT_W'(1);
      end
      if (state_r == S_RUN || state_r == S_WAIT) begin
        hit_acc_r <= hit_acc_r || tester_hit;
      end
      if (state_r == S_STEP) begin
        hit_acc_r <= 1'b0;
        rt_r      <= rt_next;
        if (!step_hit) begin
          found_r <= 1'b1;
        end
        if (i_r == ITER_W'(ITERATIONS - 1)) begin
          t_r <= rt_next;
        end else begin
          t_r <= t_next;
          i_r <= i_r + ITER_W'(1);
        end
      end
      if (out_load) begin
        count_r     <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.impact_time = out_time_r;
  assign out_ch.free_found  = out_found_r;
  assign out_ch.new_x       = out_x_r;
  assign out_ch.new_y       = out_y_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_COLLIDERS))
    else $error("collider count exceeds capacity");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the completion state");

  a_list_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> count_r == '0)
    else $error("collider list not cleared after a search");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |=> !hit_acc_r)
    else $error("hit accumulator carried into the next step");

  a_none_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_time_r == T_NONE)
    else $error("no free time found but impact time is not minus one");

endmodule
`default_nettype wire

FILE: rtl/aitb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitb_cell
// One collider slot of the shift chain; takes its neighbor's box on a shift.
// ----------------------------------------------------------------------------
module aitb_cell import aitb_pkg::*; (
  input  logic      clk,
  input  logic      shift_en,
  input  aitb_box_t d,
  output aitb_box_t q
);

  aitb_box_t box_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      box_r <= d;
    end
  end

  assign q = box_r;

endmodule
`default_nettype wire

FILE: rtl/aitb_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitb_test
// Two-stage overlap test of one collider against the moving box at time t.
// ----------------------------------------------------------------------------
module aitb_test import aitb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  aitb_box_t                ent,
  input  logic                     ent_valid,
  input  logic signed [TIME_W-1:0] t,
  input  logic signed [SUM_W-1:0]  px,
  input  logic signed [SUM_W-1:0]  py,
  input  logic [SIZE_W-1:0]        aw,
  input  logic [SIZE_W-1:0]        ah,
  output logic                     hit
);

  logic                     v1_r;
  logic signed [PROD_W-1:0] mx_r;
  logic signed [PROD_W-1:0] my_r;
  logic signed [POS_W-1:0]  cx_r;
  logic signed [POS_W-1:0]  cy_r;
  logic [SIZE_W-1:0]        cw_r;
  logic [SIZE_W-1:0]        ch_r;
  logic                     hit_r;
  logic                     hit_nxt;

  logic signed [DISP_W-1:0] dqx;
  logic signed [DISP_W-1:0] dqy;
  logic signed [CMP_W-1:0]  ql_x;
  logic signed [CMP_W-1:0]  qr_x;
  logic signed [CMP_W-1:0]  ql_y;
  logic signed [CMP_W-1:0]  qr_y;
  logic signed [CMP_W-1:0]  pl_x;
  logic signed [CMP_W-1:0]  pr_x;
  logic signed [CMP_W-1:0]  pl_y;
  logic signed [CMP_W-1:0]  pr_y;

  always_ff @(posedge clk) begin
    mx_r <= PROD_W'(t) * PROD_W'(ent.vx);
    my_r <= PROD_W'(t) * PROD_W'(ent.vy);
    cx_r <= ent.x;
    cy_r <= ent.y;
    cw_r <= ent.w;
    ch_r <= ent.h;
  end

  // Dropping the low fraction bits of the signed product floors it.
  assign dqx = mx_r[PROD_W-1:TIME_FRAC];
  assign dqy = my_r[PROD_W-1:TIME_FRAC];

  always_comb begin
    ql_x = CMP_W'(cx_r) + CMP_W'(dqx);
    qr_x = ql_x + $signed(CMP_W'(cw_r));
    ql_y = CMP_W'(cy_r) + CMP_W'(dqy);
    qr_y = ql_y + $signed(CMP_W'(ch_r));
    pl_x = CMP_W'(px);
    pr_x = pl_x + $signed(CMP_W'(aw));
    pl_y = CMP_W'(py);
    pr_y = pl_y + $signed(CMP_W'(ah));
    hit_nxt = v1_r && (pr_x > ql_x) && (pl_x < qr_x) && (pr_y > ql_y) && (pl_y < qr_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r  <= ent_valid;
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule
`default_nettype wire

FILE: dv/tb_aabb_impact_time_bisection.sv
// ----------------------------------------------------------------------------
// tb_aabb_impact_time_bisection
// Self-checking bench for the swept box time-of-impact search. Collider loads
// and search requests go in over the input channel with random gaps. A
// scoreboard keeps its own collider list, predicts each search result, and
// compares every result transaction against the oldest prediction. The result
// side stalls at random.
// ----------------------------------------------------------------------------
module tb_aabb_impact_time_bisection import aitb_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic      cmd;
    aitb_box_t box;
  } box_req_t;

  typedef struct {
    logic signed [TIME_W-1:0] impact_time;
    logic                     free_found;
    logic signed [POS_W-1:0]  new_x;
    logic signed [POS_W-1:0]  new_y;
  } impact_t;

  class impact_scoreboard;
    aitb_box_t   colliders[MAX_COLLIDERS];
    int unsigned stored;
    impact_t     expected_impacts[$];
    int unsigned failures;

    function new();
      stored   = 0;
      failures = 0;
    endfunction

    function longint disp(longint t, longint v);
      return (t * v) >>> TIME_FRAC;
    endfunction

    function bit overlaps(longint t, aitb_box_t a, aitb_box_t c);
      longint px, py, aw, ah, qx, qy, qw, qh;
      px = longint'(a.x) + disp(t, longint'(a.vx));
      py = longint'(a.y) + disp(t, longint'(a.vy));
      aw = longint'(a.w);
      ah = longint'(a.h);
      qx = longint'(c.x) + disp(t, longint'(c.vx));
      qy = longint'(c.y) + disp(t, longint'(c.vy));
      qw = longint'(c.w);
      qh = longint'(c.h);
      return (px + aw > qx) && (px < qx + qw) && (py + ah > qy) && (py < qy + qh);
    endfunction

    function logic signed [POS_W-1:0] clamp_pos(longint v);
      if (v > longint'(POS_MAX)) begin
        return POS_MAX;
      end
      if (v < longint'(POS_MIN)) begin
        return POS_MIN;
      end
      return v[POS_W-1:0];
    endfunction

    function impact_t predict_impact(aitb_box_t a);
      longint  t, rt, step;
      bit      hit, found;
      impact_t r;
      t     = longint'(T_START);
      rt    = longint'(T_NONE);
      found = 1'b0;
      for (int i = 0; i < ITERATIONS; i++) begin
        hit = 1'b0;
        for (int k = 0; k < stored; k++) begin
          if (overlaps(t, a, colliders[k])) begin
            hit = 1'b1;
          end
        end
        if (!hit) begin
          rt    = t;
          found = 1'b1;
        end
        step = 64'sd65536 >>> (i + 2);
        t = hit ? t - step : t + step;
      end
      r.impact_time = rt[TIME_W-1:0];
      r.free_found  = found;
      r.new_x       = clamp_pos(longint'(a.x) + disp(rt, longint'(a.vx)));
      r.new_y       = clamp_pos(longint'(a.y) + disp(rt, longint'(a.vy)));
      return r;
    endfunction

    function void note_input(box_req_t req);
      if (req.cmd == CMD_APPEND) begin
        if (stored < MAX_COLLIDERS) begin
          colliders[stored] = req.box;
          stored++;
        end
      end else begin
        expected_impacts.push_back(predict_impact(req.box));
        stored = 0;
      end
    endfunction

    function void check_result(impact_t got);
      impact_t exp;
      if (expected_impacts.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: unexpected result t=%0d free=%0b x=%0d y=%0d",
                   got.impact_time, got.free_found, got.new_x, got.new_y);
        end
        return;
      end
      exp = expected_impacts.pop_front();
      if (got.impact_time !== exp.impact_time || got.free_found !== exp.free_found ||
          got.new_x !== exp.new_x || got.new_y !== exp.new_y) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: expected t=%0d free=%0b x=%0d y=%0d, got t=%0d free=%0b x=%0d y=%0d",
                   exp.impact_time, exp.free_found, exp.new_x, exp.new_y,
                   got.impact_time, got.free_found, got.new_x, got.new_y);
        end
      end
    endfunction

    function int pending();
      return expected_impacts.size();
    endfunction

    function bit clean();
      return (failures == 0) && (expected_impacts.size() == 0);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  aitb_in_if  in_ch ();
  aitb_out_if out_ch ();

  aabb_impact_time_bisection u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  impact_scoreboard sb = new();
  box_req_t         stim_q[$];
  bit               in_quiet;
  bit               out_quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int spread(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic aitb_box_t mk_box(int x, int y, int w, int h, int vx, int vy);
    aitb_box_t b;
    b.x  = POS_W'(x);
    b.y  = POS_W'(y);
    b.w  = SIZE_W'(w);
    b.h  = SIZE_W'(h);
    b.vx = POS_W'(vx);
    b.vy = POS_W'(vy);
    return b;
  endfunction

  function automatic aitb_box_t near_box(int bx, int by, int s);
    return mk_box(bx + spread(s), by + spread(s), int'($urandom_range(0, s)),
                  int'($urandom_range(0, s)), spread(2 * s), spread(2 * s));
  endfunction

  task automatic add_req(logic cmd, aitb_box_t b);
    box_req_t r;
    r.cmd = cmd;
    r.box = b;
    stim_q.push_back(r);
  endtask

  task automatic send_request(box_req_t req);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      in_quiet = !in_quiet;
    end
    gap = in_quiet ? 0 : int'($urandom_range(0, 11));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= req.cmd;
    in_ch.pos_x      <= req.box.x;
    in_ch.pos_y      <= req.box.y;
    in_ch.box_width  <= req.box.w;
    in_ch.box_height <= req.box.h;
    in_ch.vel_x      <= req.box.vx;
    in_ch.vel_y      <= req.box.vy;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(req);
  endtask

  task automatic build_stimulus();
    int n_random;
    int s, bx, by, nc;
    int pmax, pmin;
    pmax = int'(POS_MAX);
    pmin = int'(POS_MIN);
    // Empty list with saturating positions, then an all-zero search.
    add_req(CMD_SEARCH, mk_box(pmax, pmin, 0, 8388607, pmin, pmax));
    add_req(CMD_SEARCH, mk_box(0, 0, 0, 0, 0, 0));
    // One collider covering the whole negative quadrant: no free time.
    add_req(CMD_APPEND, mk_box(pmin, pmin, 8388607, 8388607, 0, 0));
    add_req(CMD_SEARCH, mk_box(-4096, -4096, 256, 256, 1000, -1000));
    add_req(CMD_APPEND, mk_box(pmin, pmin, 8388607, 8388607, 0, 0));
    add_req(CMD_SEARCH, mk_box(pmin, pmin, 8388607, 8388607, pmax, pmax));
    // A full list; the ninth collider would cover the moving box but is dropped.
    for (int k = 0; k < MAX_COLLIDERS; k++) begin
      add_req(CMD_APPEND, mk_box(pmax - 256, pmax - 256, k, 8388607 - k,
                                 (k % 2) ? pmin : pmax, (k % 2) ? pmax : pmin));
    end
    add_req(CMD_APPEND, mk_box(-65536, -65536, 131072, 131072, 0, 0));
    add_req(CMD_SEARCH, mk_box(0, 0, 256, 256, 0, 0));
    // A crossing path that is hit part of the time.
    add_req(CMD_APPEND, mk_box(512, 0, 256, 256, 0, 0));
    add_req(CMD_SEARCH, mk_box(0, 0, 256, 256, -1024, 0));
    // Zero-size boxes.
    add_req(CMD_APPEND, mk_box(100, 100, 0, 300, 0, 0));
    add_req(CMD_SEARCH, mk_box(0, 0, 0, 0, -300, -300));

    n_random = 0;
    while (n_random < 1050) begin
      if ($urandom_range(0, 99) < 12) begin
        add_req(logic'($urandom_range(0, 1)),
                mk_box(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                       int'($urandom), int'($urandom)));
        n_random++;
      end else begin
        s  = 1 << $urandom_range(3, 21);
        bx = spread(1 << 22);
        by = spread(1 << 22);
        nc = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 11))
                                         : int'($urandom_range(0, MAX_COLLIDERS));
        for (int k = 0; k < nc; k++) begin
          add_req(CMD_APPEND, near_box(bx, by, s));
        end
        add_req(CMD_SEARCH, near_box(bx, by, s));
        n_random += nc + 1;
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_APPEND;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.box_width  <= '0;
    in_ch.box_height <= '0;
    in_ch.vel_x      <= '0;
    in_ch.vel_y      <= '0;
    out_ch.ready     <= 1'b0;
    in_quiet         = 1'b0;
    out_quiet        = 1'b0;
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stim_q[i]) begin
      send_request(stim_q[i]);
    end
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.clean()) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    impact_t got;
    int      gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        out_quiet = !out_quiet;
      end
      gap = out_quiet ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.impact_time = out_ch.impact_time;
      got.free_found  = out_ch.free_found;
      got.new_x       = out_ch.new_x;
      got.new_y       = out_ch.new_y;
      sb.check_result(got);
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout waiting for the search to finish");
    $display("TEST FAILED");
    $finish;
  end

endmodule
